// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the quaternion unit.
// Every check samples on clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define QAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("quaternion unit check failed");

// A same-cycle implication.
`define QAU_IMPLIES(lbl, ante, cons) \
  `QAU_ASSERT(lbl, (ante) |-> (cons))

`endif

// ----- rtl/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// qau_pkg
// Types, codes and sizes shared by the fixed-point quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

  localparam int FRAC_DEFAULT = 16;
  localparam int SQ_PER       = 4;   // root bits resolved per square-root stage
  localparam int SQ_STAGES    = 8;   // 32 root bits in total
  localparam int DIV_PER      = 4;   // quotient bits resolved per divide stage

  localparam logic [1:0] CMD_MUL  = 2'd0;
  localparam logic [1:0] CMD_NORM = 2'd1;
  localparam logic [1:0] CMD_CONJ = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic [1:0]         status;
  } rsp_t;

  // Everything a word carries down the pipeline.
  typedef struct packed {
    logic [1:0]              cmd;
    logic [3:0]              neg;
    logic [3:0][31:0]        u;
    logic [31:0]             m;
    logic [3:0][3:0][63:0]   prod;
    logic [3:0][31:0]        res;
    logic [1:0]              status;
    logic [3:0][30:0]        v;
    logic [63:0]             s;
    logic [33:0]             rem;
    logic [31:0]             root;
    logic [3:0][31:0]        drem;
    logic [3:0][31:0]        q;
  } pipe_t;

  // Sign of term j in Hamilton product component i (a[j] times b[i^j]).
  function automatic logic term_neg(input int i, input int j);
    logic n;
    n = 1'b0;
    if (i == 0) n = (j != 0);
    if (i == 1) n = (j == 3);
    if (i == 2) n = (j == 1);
    if (i == 3) n = (j == 2);
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/qau_prep.sv -----
// ----------------------------------------------------------------------------
// qau_prep
// First stage logic: the sixteen partial products, component magnitudes and
// the largest magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_prep import qau_pkg::*; (
  input  wire req_t req,
  output pipe_t     nxt
);

  logic signed [31:0] a [4];
  logic signed [31:0] b [4];

  assign a[0] = req.a_w;
  assign a[1] = req.a_x;
  assign a[2] = req.a_y;
  assign a[3] = req.a_z;
  assign b[0] = req.b_w;
  assign b[1] = req.b_x;
  assign b[2] = req.b_y;
  assign b[3] = req.b_z;

  always_comb begin
    nxt     = '0;
    nxt.cmd = req.command;
    // Signs after optional conjugation, and magnitudes that keep 2^31 exact.
    for (int j = 0; j < 4; j++) begin
      if (j == 0 || req.command != CMD_CONJ) begin
        nxt.neg[j] = a[j][31];
      end else begin
        nxt.neg[j] = !a[j][31] && (a[j] != 32'sd0);
      end
      nxt.u[j] = a[j][31] ? (~a[j] + 32'd1) : a[j];
    end
    // Largest magnitude.
    nxt.m = nxt.u[0];
    for (int j = 1; j < 4; j++) begin
      if (nxt.u[j] > nxt.m) nxt.m = nxt.u[j];
    end
    // One multiplier per product; signs are applied in the next stage.
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        nxt.prod[i][j] = a[j] * b[i ^ j];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/qau_scale.sv -----
// ----------------------------------------------------------------------------
// qau_scale
// Second stage logic: product sums with shift and saturation, and the
// prescale of the magnitudes ahead of the norm.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_scale import qau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEFAULT
) (
  input  wire pipe_t cur,
  output pipe_t      nxt
);

  logic signed [65:0] sum;
  logic signed [65:0] term;
  logic signed [65:0] sh;
  logic               sat;
  logic [4:0]         msb;
  logic               pow2;
  logic               big;
  logic [4:0]         lsh;

  always_comb begin
    nxt = cur;
    sat = 1'b0;
    sum = '0;
    sh  = '0;
    term = '0;
    // Exact sum of four products, floor shift, clamp to 32 bits.
    for (int i = 0; i < 4; i++) begin
      sum = '0;
      for (int j = 0; j < 4; j++) begin
        term = 66'($signed(cur.prod[i][j]));
        sum  = term_neg(i, j) ? (sum - term) : (sum + term);
      end
      sh = sum >>> FRAC_BITS;
      if (sh > 66'sd2147483647) begin
        nxt.res[i] = 32'h7fff_ffff;
        sat        = 1'b1;
      end else if (sh < -66'sd2147483648) begin
        nxt.res[i] = 32'h8000_0000;
        sat        = 1'b1;
      end else begin
        nxt.res[i] = sh[31:0];
      end
    end
    nxt.status = sat ? ST_SAT : ST_OK;

    // Bring the largest magnitude just under or onto 2^30.
    msb = '0;
    for (int k = 0; k < 31; k++) begin
      if (cur.m[k]) msb = 5'(k);
    end
    pow2 = ((cur.m & (cur.m - 32'd1)) == 32'd0);
    big  = cur.m > 32'h4000_0000;
    lsh  = 5'(29 - int'(msb) + int'(pow2));
    for (int j = 0; j < 4; j++) begin
      nxt.v[j] = big ? 31'(cur.u[j] >> 1) : 31'(cur.u[j] << lsh);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/qau_sqrt_step.sv -----
// ----------------------------------------------------------------------------
// qau_sqrt_step
// One stage of the digit-by-digit integer square root of the sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_sqrt_step import qau_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire pipe_t cur,
  output pipe_t      nxt
);

  logic [33:0] rem;
  logic [33:0] trial;
  logic [31:0] root;
  int          idx;

  always_comb begin
    nxt   = cur;
    rem   = cur.rem;
    root  = cur.root;
    trial = '0;
    idx   = 0;
    // Each step brings down two radicand bits and decides one root bit.
    for (int j = 0; j < SQ_PER; j++) begin
      idx   = SQ_STAGES * SQ_PER - 1 - (STAGE * SQ_PER + j);
      rem   = {rem[31:0], cur.s[2 * idx + 1 -: 2]};
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[30:0], 1'b1};
      end else begin
        root = {root[30:0], 1'b0};
      end
    end
    nxt.rem  = rem;
    nxt.root = root;
  end

endmodule

`default_nettype wire

// ----- rtl/qau_div_step.sv -----
// ----------------------------------------------------------------------------
// qau_div_step
// One stage of the restoring division of each scaled magnitude by the root,
// four lanes side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_div_step import qau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEFAULT,
  parameter int STAGE     = 0
) (
  input  wire pipe_t cur,
  output pipe_t      nxt
);

  logic [32:0] t;
  logic [31:0] r;
  logic [31:0] qq;
  logic        bit_q;
  int          gi;

  always_comb begin
    nxt   = cur;
    t     = '0;
    r     = '0;
    qq    = '0;
    bit_q = 1'b0;
    gi    = 0;
    for (int l = 0; l < 4; l++) begin
      r  = cur.drem[l];
      qq = cur.q[l];
      for (int j = 0; j < DIV_PER; j++) begin
        gi = STAGE * DIV_PER + j;
        if (gi <= FRAC_BITS) begin
          // The first step compares the integer part, later ones shift in zeros.
          t     = (gi == 0) ? {2'b00, cur.v[l]} : {r, 1'b0};
          bit_q = (t >= {1'b0, cur.root});
          if (bit_q) t = t - {1'b0, cur.root};
          r  = t[31:0];
          qq = {qq[30:0], bit_q};
        end
      end
      nxt.drem[l] = r;
      nxt.q[l]    = qq;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/quaternion_arith_unit.sv -----
// Pipeline from accept to rsp_valid: prep, scale and sum-of-squares stages, then the square-root
// stages, the divide stages and the output register; the number of divide stages follows FRAC_BITS.
// Throughput: one word per cycle; every stage has its own valid bit and a stage
// holds only while the stage after it is full and stalled.
// Reset: synchronous rst clears every valid bit; data registers are not reset.
`default_nettype none

`include "assert_macros.svh"

module quaternion_arith_unit import qau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int DIV_STAGES = (FRAC_BITS + DIV_PER) / DIV_PER;
  localparam int SQ_FIRST   = 3;
  localparam int DIV_FIRST  = SQ_FIRST + SQ_STAGES;
  localparam int NP         = DIV_FIRST + DIV_STAGES;

  pipe_t stg [NP];
  pipe_t nxt [NP];
  logic  vld [NP];
  logic  rdy [NP+1];
  rsp_t  fin;
  logic [61:0] sq [4];
  logic  root_chk;
  logic  unit_chk;

  // Stage logic.
  qau_prep u_prep (
    .req (req),
    .nxt (nxt[0])
  );

  qau_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .cur (stg[0]),
    .nxt (nxt[1])
  );

  // Sum of squares of the prescaled magnitudes.
  always_comb begin
    nxt[2] = stg[1];
    for (int j = 0; j < 4; j++) begin
      sq[j] = stg[1].v[j] * stg[1].v[j];
    end
    nxt[2].s    = 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]) + 64'(sq[3]);
    nxt[2].rem  = '0;
    nxt[2].root = '0;
    nxt[2].drem = '0;
    nxt[2].q    = '0;
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    qau_sqrt_step #(.STAGE(k)) u_sqrt (
      .cur (stg[SQ_FIRST + k - 1]),
      .nxt (nxt[SQ_FIRST + k])
    );
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    qau_div_step #(.FRAC_BITS(FRAC_BITS), .STAGE(k)) u_div (
      .cur (stg[DIV_FIRST + k - 1]),
      .nxt (nxt[DIV_FIRST + k])
    );
  end

  // Result selection by command.
  always_comb begin
    fin = '0;
    unique case (stg[NP-1].cmd)
      CMD_MUL: begin
        fin.r_w    = stg[NP-1].res[0];
        fin.r_x    = stg[NP-1].res[1];
        fin.r_y    = stg[NP-1].res[2];
        fin.r_z    = stg[NP-1].res[3];
        fin.status = stg[NP-1].status;
      end
      CMD_NORM, CMD_CONJ: begin
        if (stg[NP-1].m == 32'd0) begin
          fin.status = ST_ZERO;
        end else begin
          fin.r_w = stg[NP-1].neg[0] ? -stg[NP-1].q[0] : stg[NP-1].q[0];
          fin.r_x = stg[NP-1].neg[1] ? -stg[NP-1].q[1] : stg[NP-1].q[1];
          fin.r_y = stg[NP-1].neg[2] ? -stg[NP-1].q[2] : stg[NP-1].q[2];
          fin.r_z = stg[NP-1].neg[3] ? -stg[NP-1].q[3] : stg[NP-1].q[3];
          fin.status = ST_OK;
        end
      end
      CMD_NONE: begin
        fin = '0;
      end
      default: begin
        fin = '0;
      end
    endcase
  end

  // Ready flows back: a stage moves when it is empty or the next one moves.
  assign rdy[NP] = !rsp_valid || rsp_ready;
  for (genvar k = 0; k < NP; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign req_ready = rdy[0];

  // Pipeline registers.
  for (genvar k = 0; k < NP; k++) begin : g_stage
    logic up_vld;
    if (k == 0) begin : g_head
      assign up_vld = req_valid;
    end else begin : g_body
      assign up_vld = vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= up_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && up_vld) begin
        stg[k] <= nxt[k];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rdy[NP]) begin
      rsp_valid <= vld[NP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NP] && vld[NP-1]) begin
      rsp <= fin;
    end
  end

  // Conditions under which a normalize word carries a nonzero norm.
  assign root_chk = vld[DIV_FIRST-1] && stg[DIV_FIRST-1].cmd != CMD_MUL &&
                    stg[DIV_FIRST-1].cmd != CMD_NONE && stg[DIV_FIRST-1].m != 32'd0;
  assign unit_chk = vld[NP-1] && stg[NP-1].m != 32'd0 &&
                    (stg[NP-1].cmd == CMD_NORM || stg[NP-1].cmd == CMD_CONJ);

  // A stalled stage keeps its word.
  for (genvar k = 0; k < NP; k++) begin : g_chk_hold
    `QAU_ASSERT(a_stage_hold, (vld[k] && !rdy[k+1]) |=> vld[k])
  end

  // The root of a nonzero norm never falls below 2^29.
  `QAU_IMPLIES(a_root_floor, root_chk, stg[DIV_FIRST-1].root >= 32'h2000_0000)

  // A normalized magnitude never exceeds one.
  for (genvar l = 0; l < 4; l++) begin : g_chk_unit
    `QAU_IMPLIES(a_unit_mag, unit_chk, stg[NP-1].q[l] <= (32'd1 << FRAC_BITS))
  end

endmodule

`default_nettype wire
